// ----- design/dtf_pkg.sv -----
// ----------------------------------------------------------------------------
// dtf_pkg: shared types, constants and saturating arithmetic
// Time words are signed Q32.32 in 64 bits; loop gains are unsigned Q0.32.
// ----------------------------------------------------------------------------
package dtf_pkg;

	localparam int TIME_BITS = 64;
	localparam int GAIN_BITS = 32;
	localparam int NOM_BITS  = 63;
	localparam int IDX_BITS  = 2;
	localparam int OUT_CNT_BITS = 32;

	localparam logic signed [TIME_BITS-1:0] TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
	localparam logic signed [TIME_BITS-1:0] TIME_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

	// register indexes of the write port
	localparam logic [IDX_BITS-1:0] REG_NOMINAL_PERIOD = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_GAIN_B         = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_GAIN_C         = 2'd2;

	// request op codes
	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// start request for one serial gain multiply
	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [TIME_BITS-1:0] mag;
	} mul_req_t;

	// add, clamping at the signed limits
	function automatic logic signed [TIME_BITS-1:0] sat_add(
		input logic signed [TIME_BITS-1:0] a,
		input logic signed [TIME_BITS-1:0] b
	);
		logic signed [TIME_BITS-1:0] r;
		r = a + b;
		if (a[TIME_BITS-1] == b[TIME_BITS-1] && r[TIME_BITS-1] != a[TIME_BITS-1]) begin
			r = a[TIME_BITS-1] ? TIME_MIN : TIME_MAX;
		end
		return r;
	endfunction

	// subtract, clamping at the signed limits
	function automatic logic signed [TIME_BITS-1:0] sat_sub(
		input logic signed [TIME_BITS-1:0] a,
		input logic signed [TIME_BITS-1:0] b
	);
		logic signed [TIME_BITS-1:0] r;
		r = a - b;
		if (a[TIME_BITS-1] != b[TIME_BITS-1] && r[TIME_BITS-1] != a[TIME_BITS-1]) begin
			r = a[TIME_BITS-1] ? TIME_MIN : TIME_MAX;
		end
		return r;
	endfunction

endpackage

// ----- design/dtf_ser_mul.sv -----
// ----------------------------------------------------------------------------
// dtf_ser_mul: bit-serial gain multiplier
// Forms round(gain * e / 2^32), ties away from zero, one gain bit per cycle.
// ----------------------------------------------------------------------------
module dtf_ser_mul import dtf_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mul_req_t                    req,
	input  logic [GAIN_BITS-1:0]        gain,
	output logic                        done,
	output logic signed [TIME_BITS-1:0] result
);

	localparam int CntW = $clog2(GAIN_BITS);
	localparam logic [CntW-1:0] CntLast = CntW'(GAIN_BITS - 1);

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic [CntW-1:0]      cnt_q;
	logic [GAIN_BITS-1:0] g_q;
	logic [TIME_BITS-1:0] mag_q;
	logic                 neg_q;
	logic [TIME_BITS-1:0] acc_q;
	logic [GAIN_BITS-1:0] lo_q;
	logic signed [TIME_BITS-1:0] result_q;
	logic [TIME_BITS:0]   sum;

	// partial sum for the current gain bit
	assign sum = {1'b0, acc_q} + (g_q[0] ? {1'b0, mag_q} : '0);

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntLast) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift-add datapath, then round and apply the sign
	always_ff @(posedge clk) begin
		if (req.start) begin
			g_q   <= gain;
			mag_q <= req.mag;
			neg_q <= req.neg;
			acc_q <= '0;
			lo_q  <= '0;
		end else if (busy_q) begin
			acc_q <= sum[TIME_BITS:1];
			lo_q  <= {sum[0], lo_q[GAIN_BITS-1:1]};
			g_q   <= g_q >> 1;
		end else if (fin_q) begin
			// -(acc + r) folded into one add as ~acc + (1 - r)
			if (neg_q) begin
				result_q <= ~acc_q + {{(TIME_BITS-1){1'b0}}, !lo_q[GAIN_BITS-1]};
			end else begin
				result_q <= acc_q + TIME_BITS'(lo_q[GAIN_BITS-1]);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- design/dtf_ser_div.sv -----
// ----------------------------------------------------------------------------
// dtf_ser_div: bit-serial signed divider
// Divides a signed time word by a nonzero cycle count, truncating toward
// zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtf_ser_div import dtf_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [TIME_BITS-1:0] dividend,
	input  logic [COUNT_BITS-1:0]       divisor,
	output logic                        done,
	output logic signed [TIME_BITS-1:0] quotient
);

	localparam int CntW = $clog2(TIME_BITS);
	localparam logic [CntW-1:0] CntLast = CntW'(TIME_BITS - 1);

	logic                  busy_q;
	logic                  fin_q;
	logic                  done_q;
	logic [CntW-1:0]       cnt_q;
	logic                  neg_q;
	logic [TIME_BITS-1:0]  num_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic signed [TIME_BITS-1:0] quot_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  qbit;

	// trial subtraction for the next quotient bit
	assign trial = {rem_q, num_q[TIME_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = !diff[COUNT_BITS];

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntLast) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// restoring division on the magnitude, sign restored at the end
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[TIME_BITS-1];
			num_q <= dividend[TIME_BITS-1] ? -dividend : dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			num_q <= {num_q[TIME_BITS-2:0], qbit};
		end else if (fin_q) begin
			quot_q <= neg_q ? -num_q : num_q;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- design/dll_timestamp_filter.sv -----
// ----------------------------------------------------------------------------
// dll_timestamp_filter: second-order delay-locked loop time filter
// Smooths per-period timestamps and reports drift and jitter statistics.
// ----------------------------------------------------------------------------
// One request at a time. A restart request gives no result; a seeding sample
// goes straight to the output state. A later sample passes the error, prepare
// and start states, which form the loop error and launch the serial units;
// the wait state then holds until the 64-step bit-serial divider that forms
// the average rate error and the two 32-step gain multipliers, which run
// alongside it, have finished. Two update states close the loop, and the
// output state loads the result into the output register once the output
// side can take it. The next request is taken in the cycle after the load.
// The result waits in an output register, so the next request is taken
// while it is still unread.
// Write nominal_period, gain_b and gain_c only while the block is idle.
// ----------------------------------------------------------------------------
module dll_timestamp_filter import dtf_pkg::*; #(
	parameter int TIME_FRAC_BITS = 32,
	parameter int COUNT_BITS     = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [IDX_BITS-1:0]         wr_index,
	input  logic [NOM_BITS-1:0]         wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic signed [TIME_BITS-1:0] sample_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [TIME_BITS-1:0] smoothed_time,
	output logic signed [TIME_BITS-1:0] predicted_time,
	output logic signed [TIME_BITS-1:0] nominal_time,
	output logic signed [TIME_BITS-1:0] smoothed_drift,
	output logic signed [TIME_BITS-1:0] nominal_drift,
	output logic signed [TIME_BITS-1:0] smoothed_jitter,
	output logic signed [TIME_BITS-1:0] raw_jitter,
	output logic [OUT_CNT_BITS-1:0]     cycles_seen
);

	localparam logic [NOM_BITS-1:0] NomPeriodReset =
		NOM_BITS'((64'd1 << TIME_FRAC_BITS) / 1000);
	localparam int CntExtW = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ERR  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_UPD1 = 3'd5;
	localparam logic [2:0] ST_UPD2 = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]           state_q;
	logic [NOM_BITS-1:0]  nom_period_q;
	logic [GAIN_BITS-1:0] gain_b_q;
	logic [GAIN_BITS-1:0] gain_c_q;
	logic                 started_q;
	logic                 got_b_q;
	logic                 got_c_q;
	logic                 got_div_q;
	logic                 out_valid_q;

	logic signed [TIME_BITS-1:0] sample_q;
	logic signed [TIME_BITS-1:0] current_q;
	logic signed [TIME_BITS-1:0] next_q;
	logic signed [TIME_BITS-1:0] period_q;
	logic signed [TIME_BITS-1:0] last_q;
	logic signed [TIME_BITS-1:0] dev_q;
	logic signed [TIME_BITS-1:0] sp_err_q;
	logic signed [TIME_BITS-1:0] raw_err_q;
	logic [COUNT_BITS-1:0]       cnt_q;
	logic signed [TIME_BITS-1:0] e_q;
	logic [TIME_BITS-1:0]        mag_q;
	logic                        neg_q;
	logic signed [TIME_BITS-1:0] drift_s_q;
	logic signed [TIME_BITS-1:0] drift_n_q;
	logic signed [TIME_BITS-1:0] pb_q;
	logic signed [TIME_BITS-1:0] pc_q;
	logic signed [TIME_BITS-1:0] rate_q;
	logic signed [TIME_BITS-1:0] step_q;
	logic signed [TIME_BITS-1:0] sj_q;
	logic signed [TIME_BITS-1:0] rj_q;

	logic signed [TIME_BITS-1:0] o_smoothed_q;
	logic signed [TIME_BITS-1:0] o_predicted_q;
	logic signed [TIME_BITS-1:0] o_nominal_q;
	logic signed [TIME_BITS-1:0] o_drift_s_q;
	logic signed [TIME_BITS-1:0] o_drift_n_q;
	logic signed [TIME_BITS-1:0] o_sj_q;
	logic signed [TIME_BITS-1:0] o_rj_q;
	logic [OUT_CNT_BITS-1:0]     o_cnt_q;

	logic signed [TIME_BITS-1:0] per;
	logic                        in_fire;
	logic                        out_load;
	logic [CntExtW-1:0]          cnt_ext;
	mul_req_t                    mul_req;
	logic                        mul_b_done;
	logic                        mul_c_done;
	logic signed [TIME_BITS-1:0] mul_b_res;
	logic signed [TIME_BITS-1:0] mul_c_res;
	logic                        div_start;
	logic                        div_done;
	logic signed [TIME_BITS-1:0] div_res;

	assign per      = {1'b0, nom_period_q};
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign cnt_ext  = CntExtW'(cnt_q);

	// launch both gain products and the rate division together
	assign mul_req.start = (state_q == ST_START);
	assign mul_req.neg   = neg_q;
	assign mul_req.mag   = mag_q;
	assign div_start     = (state_q == ST_START);

	dtf_ser_mul u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.gain   (gain_b_q),
		.done   (mul_b_done),
		.result (mul_b_res)
	);

	dtf_ser_mul u_mul_c (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.gain   (gain_c_q),
		.done   (mul_c_done),
		.result (mul_c_res)
	);

	dtf_ser_div #(
		.COUNT_BITS (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (drift_n_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_res)
	);

	// take configuration writes; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_period_q <= NomPeriodReset;
			gain_b_q     <= '0;
			gain_c_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_NOMINAL_PERIOD: nom_period_q <= wr_data;
				REG_GAIN_B:         gain_b_q     <= wr_data[GAIN_BITS-1:0];
				REG_GAIN_C:         gain_c_q     <= wr_data[GAIN_BITS-1:0];
				default:            ;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			got_b_q     <= 1'b0;
			got_c_q     <= 1'b0;
			got_div_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mul_b_done) begin
				got_b_q <= 1'b1;
			end
			if (mul_c_done) begin
				got_c_q <= 1'b1;
			end
			if (div_done) begin
				got_div_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (op == OP_RESTART) begin
							started_q <= 1'b0;
						end else if (!started_q) begin
							started_q <= 1'b1;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_ERR:   state_q <= ST_PREP;
				ST_PREP:  state_q <= ST_START;
				ST_START: begin
					got_b_q   <= 1'b0;
					got_c_q   <= 1'b0;
					got_div_q <= 1'b0;
					state_q   <= ST_WAIT;
				end
				ST_WAIT: begin
					if (got_b_q && got_c_q && got_div_q) begin
						state_q <= ST_UPD1;
					end
				end
				ST_UPD1:  state_q <= ST_UPD2;
				ST_UPD2:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// loop datapath
	always_ff @(posedge clk) begin
		if (mul_b_done) begin
			pb_q <= mul_b_res;
		end
		if (mul_c_done) begin
			pc_q <= mul_c_res;
		end
		if (div_done) begin
			rate_q <= div_res;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && op == OP_SAMPLE) begin
					sample_q <= sample_time;
					if (!started_q) begin
						// seed the loop from this sample
						period_q  <= per;
						current_q <= sample_time;
						next_q    <= sat_add(sample_time, per);
						dev_q     <= sample_time;
						last_q    <= sample_time;
						sp_err_q  <= '0;
						raw_err_q <= '0;
						cnt_q     <= '0;
						drift_s_q <= '0;
						drift_n_q <= '0;
						sj_q      <= '0;
						rj_q      <= '0;
					end
				end
			end
			ST_ERR: begin
				// loop error, period differences, advance the nominal clock
				e_q       <= sat_sub(sample_q, next_q);
				sp_err_q  <= sat_sub(next_q, current_q);
				raw_err_q <= sat_sub(sample_q, last_q);
				current_q <= next_q;
				dev_q     <= sat_add(dev_q, per);
				if (cnt_q != '1) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_PREP: begin
				neg_q     <= e_q[TIME_BITS-1];
				mag_q     <= e_q[TIME_BITS-1] ? -e_q : e_q;
				sp_err_q  <= sat_sub(sp_err_q, per);
				raw_err_q <= sat_sub(raw_err_q, per);
				drift_s_q <= sat_sub(current_q, sample_q);
				drift_n_q <= sat_sub(dev_q, sample_q);
				last_q    <= sample_q;
			end
			ST_UPD1: begin
				step_q   <= sat_add(pb_q, period_q);
				period_q <= sat_add(period_q, pc_q);
				sj_q     <= sat_sub(sp_err_q, rate_q);
				rj_q     <= sat_sub(raw_err_q, rate_q);
			end
			ST_UPD2: begin
				next_q <= sat_add(next_q, step_q);
			end
			default: ;
		endcase
	end

	// hold the result for the output side
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_smoothed_q  <= current_q;
			o_predicted_q <= next_q;
			o_nominal_q   <= dev_q;
			o_drift_s_q   <= drift_s_q;
			o_drift_n_q   <= drift_n_q;
			o_sj_q        <= sj_q;
			o_rj_q        <= rj_q;
			o_cnt_q       <= cnt_ext[OUT_CNT_BITS-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign smoothed_time   = o_smoothed_q;
	assign predicted_time  = o_predicted_q;
	assign nominal_time    = o_nominal_q;
	assign smoothed_drift  = o_drift_s_q;
	assign nominal_drift   = o_drift_n_q;
	assign smoothed_jitter = o_sj_q;
	assign raw_jitter      = o_rj_q;
	assign cycles_seen     = o_cnt_q;

`ifndef SYNTHESIS
	// serial units only finish while the sequencer waits for them
	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_b_done || mul_c_done) |-> state_q == ST_WAIT)
		else $error("gain multiplier finished outside the wait state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider finished outside the wait state");

	// restart drops the seed and leaves the block ready
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_RESTART) |=> (!started_q && state_q == ST_IDLE))
		else $error("restart did not clear the loop");

	// a finished result is always presented
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == ST_IDLE))
		else $error("result not presented after load");
`endif

endmodule
